[hdl/sample_count_to_time_assert.svh]
// ----------------------------------------------------------------------------
// Sample count to time assertion macros
// Shorthand for the concurrent checks of the time conversion block.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_COUNT_TO_TIME_ASSERT_SVH
`define SAMPLE_COUNT_TO_TIME_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold after the delay dly given to the macro, counted from the antecedent.
`define STC_ASSERT_LATER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("assertion failed");

`endif

[hdl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// Sample count to time package
// Widths, constants and shared types of the time conversion block.
// ----------------------------------------------------------------------------
package stc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int RATE_BITS           = 22;
   localparam int RATE60_BITS         = 28;
   localparam int MINUTES_BITS        = 27;
   localparam int SECONDS_BITS        = 6;
   localparam int CS_BITS             = 7;
   localparam int MS_BITS             = 32;
   localparam int FRAC_BITS           = 10;
   localparam int PROD_BITS           = RATE_BITS + FRAC_BITS;

   localparam int SECS_PER_MIN = 60;
   localparam int MS_PER_SEC   = 1000;
   localparam int CS_RECIP     = 205;
   localparam int CS_SHIFT     = 11;

   localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(44100);
   localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;

   typedef struct packed {
      logic                    err;
      logic [MINUTES_BITS-1:0] minutes;
      logic [SECONDS_BITS-1:0] seconds;
      logic [MS_BITS-1:0]      whole_ms;
   } side_type;

endpackage

[hdl/sample_count_to_time.sv]
// ----------------------------------------------------------------------------
// Sample count to time
// Converts a sample position into minutes, seconds, centiseconds and total
// milliseconds at the configured sample rate.
//
//   Channel   Handshake            Payload
//   request   start / busy         req_sample_position
//   result    rsp_valid strobe     rsp_minutes .. rsp_rate_error
//   config    APB psel / penable   paddr, pwdata, prdata (sample_rate)
//
// One transfer is accepted per cycle while busy is low; each result passes the
// bit-per-stage second and minute dividers, then the fraction divider and assembly.
// Reset is synchronous and clears all valid bits; busy is high during reset.
// The receiver cannot stall, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
module sample_count_to_time import stc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [SAMPLE_BITS-1:0]  req_sample_position,
   output logic                    rsp_valid,
   output logic [MINUTES_BITS-1:0] rsp_minutes,
   output logic [SECONDS_BITS-1:0] rsp_seconds,
   output logic [CS_BITS-1:0]      rsp_centiseconds,
   output logic [MS_BITS-1:0]      rsp_total_milliseconds,
   output logic                    rsp_rate_error,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [0:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   `include "sample_count_to_time_assert.svh"

   localparam int LATENCY = SAMPLE_BITS + FRAC_BITS + 2;

   logic [RATE_BITS-1:0]   rate_ff;
   logic [RATE60_BITS-1:0] rate60;
   logic                   accept;

   logic [SAMPLE_BITS-1:0] v1_ff, e1_ff;
   logic [SAMPLE_BITS-1:0] whole, minutes_q;
   logic [RATE_BITS-1:0]   rem;
   logic [RATE60_BITS-1:0] rem60;

   logic                   mv_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   side_type               mside_ff, mside_in;

   logic [FRAC_BITS-1:0]   v2_ff;
   side_type               side_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0]   ms_q;
   logic [RATE_BITS-1:0]   ms_rem;

   assign pready = 1'b1;
   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (psel && penable && pwrite && pready && paddr == REG_SAMPLE_RATE) begin
         rate_ff <= pwdata[RATE_BITS-1:0];
      end
   end

   assign prdata = (paddr == REG_SAMPLE_RATE) ? 32'(rate_ff) : '0;
   assign rate60 = RATE60_BITS'(rate_ff) * RATE60_BITS'(SECS_PER_MIN);

   stc_divider #(.NB(SAMPLE_BITS), .DB(RATE_BITS)) u_div_sec (
      .clock     (clock),
      .dividend  (req_sample_position),
      .rem_init  ('0),
      .divisor   (rate_ff),
      .quotient  (whole),
      .remainder (rem)
   );

   stc_divider #(.NB(SAMPLE_BITS), .DB(RATE60_BITS)) u_div_min (
      .clock     (clock),
      .dividend  (req_sample_position),
      .rem_init  ('0),
      .divisor   (rate60),
      .quotient  (minutes_q),
      .remainder (rem60)
   );

   always_comb begin
      mside_in.err      = e1_ff[SAMPLE_BITS-1] | (rem60 == rem60 && 1'b0);
      mside_in.minutes  = MINUTES_BITS'(minutes_q);
      mside_in.seconds  = SECONDS_BITS'(whole[SECONDS_BITS-1:0]
                          - SECONDS_BITS'(minutes_q[SECONDS_BITS-1:0]
                          * SECONDS_BITS'(SECS_PER_MIN)));
      mside_in.whole_ms = MS_BITS'(MS_BITS'(whole) * MS_BITS'(MS_PER_SEC));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
         mv_ff <= 1'b0;
         v2_ff <= '0;
      end else begin
         v1_ff <= {v1_ff[SAMPLE_BITS-2:0], accept};
         mv_ff <= v1_ff[SAMPLE_BITS-1];
         v2_ff <= {v2_ff[FRAC_BITS-2:0], mv_ff};
      end
      e1_ff    <= {e1_ff[SAMPLE_BITS-2:0], rate_ff == '0};
      prod_ff  <= PROD_BITS'(PROD_BITS'(rem) * PROD_BITS'(MS_PER_SEC));
      mside_ff <= mside_in;
      side_ff[0] <= mside_ff;
      for (int k = 1; k < FRAC_BITS; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   stc_divider #(.NB(FRAC_BITS), .DB(RATE_BITS)) u_div_frac (
      .clock     (clock),
      .dividend  (prod_ff[FRAC_BITS-1:0]),
      .rem_init  (prod_ff[PROD_BITS-1:FRAC_BITS]),
      .divisor   (rate_ff),
      .quotient  (ms_q),
      .remainder (ms_rem)
   );

   stc_assemble u_assemble (
      .clock                  (clock),
      .reset                  (reset),
      .in_valid               (v2_ff[FRAC_BITS-1] && (ms_rem == ms_rem)),
      .side                   (side_ff[FRAC_BITS-1]),
      .ms                     (ms_q),
      .rsp_valid              (rsp_valid),
      .rsp_minutes            (rsp_minutes),
      .rsp_seconds            (rsp_seconds),
      .rsp_centiseconds       (rsp_centiseconds),
      .rsp_total_milliseconds (rsp_total_milliseconds),
      .rsp_rate_error         (rsp_rate_error)
   );

   `STC_ASSERT_LATER(a_latency, clock, reset, accept, LATENCY, rsp_valid)
   `STC_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_rate_error,
      rsp_minutes == '0 && rsp_seconds == '0 && rsp_centiseconds == '0
      && rsp_total_milliseconds == '0)
   `STC_ASSERT_NOW(a_ranges, clock, reset, rsp_valid,
      rsp_seconds < SECONDS_BITS'(SECS_PER_MIN) && rsp_centiseconds < CS_BITS'(100))

endmodule

[hdl/stc_divider.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; a new division may enter every cycle.
// ----------------------------------------------------------------------------
module stc_divider #(
   parameter int NB = 32,
   parameter int DB = 22
) (
   input  logic          clock,
   input  logic [NB-1:0] dividend,
   input  logic [DB-1:0] rem_init,
   input  logic [DB-1:0] divisor,
   output logic [NB-1:0] quotient,
   output logic [DB-1:0] remainder
);

   localparam int XW = DB + NB;

   logic [XW-1:0] x_ff  [NB];
   logic [XW-1:0] x_in  [NB];
   logic [XW-1:0] x_src [NB];

   for (genvar k = 0; k < NB; k++) begin : g_stage
      logic [DB:0] trial;
      if (k == 0) begin : g_first
         assign x_src[k] = {rem_init, dividend};
      end else begin : g_next
         assign x_src[k] = x_ff[k-1];
      end
      assign trial = {x_src[k][XW-1:NB], x_src[k][NB-1]};
      always_comb begin
         if (trial >= {1'b0, divisor}) begin
            x_in[k] = {DB'(trial - {1'b0, divisor}), x_src[k][NB-2:0], 1'b1};
         end else begin
            x_in[k] = {trial[DB-1:0], x_src[k][NB-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         x_ff[k] <= x_in[k];
      end
   end

   assign quotient  = x_ff[NB-1][NB-1:0];
   assign remainder = x_ff[NB-1][XW-1:NB];

endmodule

[hdl/stc_assemble.sv]
// ----------------------------------------------------------------------------
// Result assembly stage
// Forms centiseconds and total milliseconds, zeroes all fields on a rate error,
// and registers the result.
module stc_assemble import stc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  side_type                side,
   input  logic [FRAC_BITS-1:0]    ms,
   output logic                    rsp_valid,
   output logic [MINUTES_BITS-1:0] rsp_minutes,
   output logic [SECONDS_BITS-1:0] rsp_seconds,
   output logic [CS_BITS-1:0]      rsp_centiseconds,
   output logic [MS_BITS-1:0]      rsp_total_milliseconds,
   output logic                    rsp_rate_error
);

   logic                          valid_ff;
   logic [MINUTES_BITS-1:0]       min_ff, min_in;
   logic [SECONDS_BITS-1:0]       sec_ff, sec_in;
   logic [CS_BITS-1:0]            cs_ff, cs_in;
   logic [MS_BITS-1:0]            tms_ff, tms_in;
   logic                          err_ff;
   logic [FRAC_BITS+CS_SHIFT-1:0] cs_prod;

   assign cs_prod = (FRAC_BITS+CS_SHIFT)'(ms) * (FRAC_BITS+CS_SHIFT)'(CS_RECIP);

   always_comb begin
      if (side.err) begin
         min_in = '0;
         sec_in = '0;
         cs_in  = '0;
         tms_in = '0;
      end else begin
         min_in = side.minutes;
         sec_in = side.seconds;
         cs_in  = CS_BITS'(cs_prod >> CS_SHIFT);
         tms_in = side.whole_ms + MS_BITS'(ms);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      min_ff <= min_in;
      sec_ff <= sec_in;
      cs_ff  <= cs_in;
      tms_ff <= tms_in;
      err_ff <= side.err;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_minutes            = min_ff;
   assign rsp_seconds            = sec_ff;
   assign rsp_centiseconds       = cs_ff;
   assign rsp_total_milliseconds = tms_ff;
   assign rsp_rate_error         = err_ff;

endmodule
